>>> design/prt_pkg.sv
package prt_pkg;

   localparam int OP_W     = 2;
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int NUM_W    = 7;
   localparam int STATUS_W = 3;

   // request codes
   localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
   localparam logic [OP_W-1:0] OP_LIST     = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISS  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ENTRY = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd5;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
      logic remove;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
   } stat_type;

endpackage

>>> design/prt_ctrl.sv
module prt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [prt_pkg::OP_W-1:0] req_type,
   input  prt_pkg::stat_type        stat,
   output prt_pkg::cmd_type         cmd,
   output logic                     busy
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;
   localparam logic [1:0] S_REMOVE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_type == prt_pkg::OP_REGISTER || req_type == prt_pkg::OP_LIST) begin
                  cmd.load = 1'b1;
                  state_in = S_SCAN;
               end else if (req_type == prt_pkg::OP_REMOVE) begin
                  cmd.load = 1'b1;
                  state_in = S_REMOVE;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         S_REMOVE: begin
            cmd.remove = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> design/prt_dpath.sv
module prt_dpath #(
   parameter int CAPACITY = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  prt_pkg::cmd_type             cmd,
   output prt_pkg::stat_type            stat,
   input  logic [prt_pkg::OP_W-1:0]     req_type,
   input  logic [prt_pkg::ADDR_W-1:0]   req_peer_addr,
   input  logic [prt_pkg::PORT_W-1:0]   req_peer_port,
   input  logic [prt_pkg::NUM_W-1:0]    req_peer_number,
   output logic                         rsp_valid,
   output logic [prt_pkg::STATUS_W-1:0] rsp_status,
   output logic [prt_pkg::ADDR_W-1:0]   rsp_entry_addr,
   output logic [prt_pkg::PORT_W-1:0]   rsp_entry_port,
   output logic [prt_pkg::NUM_W-1:0]    rsp_entry_number,
   output logic                         rsp_last
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // slot storage, read data registered
   logic [prt_pkg::ADDR_W-1:0] addr_mem [CAPACITY];
   logic [prt_pkg::PORT_W-1:0] port_mem [CAPACITY];

   logic [CAPACITY-1:0] active_ff, active_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;

   logic [prt_pkg::OP_W-1:0]   op_ff;
   logic [prt_pkg::ADDR_W-1:0] addr_ff;
   logic [prt_pkg::PORT_W-1:0] port_ff;
   logic [prt_pkg::NUM_W-1:0]  number_ff;

   logic                       rd_vld_ff, rd_vld_in;
   logic                       rd_act_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic [prt_pkg::ADDR_W-1:0] rd_addr_ff;
   logic [prt_pkg::PORT_W-1:0] rd_port_ff;

   logic                       dup_ff, dup_in;
   logic                       held_vld_ff, held_vld_in;
   logic [prt_pkg::ADDR_W-1:0] held_addr_ff, held_addr_in;
   logic [prt_pkg::PORT_W-1:0] held_port_ff, held_port_in;
   logic [prt_pkg::NUM_W-1:0]  held_num_ff, held_num_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [prt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [prt_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [prt_pkg::PORT_W-1:0]   rsp_port_ff, rsp_port_in;
   logic [prt_pkg::NUM_W-1:0]    rsp_num_ff, rsp_num_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                       mem_we;
   logic [IDX_W-1:0]           wr_idx;
   logic [IDX_W-1:0]           scan_idx;
   logic [IDX_W-1:0]           rm_idx;
   logic [prt_pkg::NUM_W-1:0]  fill_num;
   logic                       scan_end;
   logic                       full;
   logic                       rm_hit;

   assign scan_idx = scan_ff[IDX_W-1:0];
   assign wr_idx   = fill_ff[IDX_W-1:0];
   assign fill_num = prt_pkg::NUM_W'(fill_ff);
   assign rm_idx   = IDX_W'(number_ff - prt_pkg::NUM_W'(1));
   assign scan_end = (scan_ff == fill_ff);
   assign full     = (fill_ff == CNT_W'(CAPACITY));
   assign stat.scan_end = scan_end;

   always_comb begin
      rm_hit = 1'b0;
      if (number_ff != '0 && number_ff <= fill_num) begin
         rm_hit = active_ff[rm_idx];
      end
   end

   always_comb begin
      active_in     = active_ff;
      fill_in       = fill_ff;
      scan_in       = scan_ff;
      rd_vld_in     = 1'b0;
      dup_in        = dup_ff;
      held_vld_in   = held_vld_ff;
      held_addr_in  = held_addr_ff;
      held_port_in  = held_port_ff;
      held_num_in   = held_num_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;

      if (cmd.load) begin
         scan_in     = '0;
         dup_in      = 1'b0;
         held_vld_in = 1'b0;
      end

      if (cmd.scan && !scan_end) begin
         rd_vld_in = 1'b1;
         scan_in   = scan_ff + CNT_W'(1);
      end

      // slot data read in the previous cycle
      if (rd_vld_ff && rd_act_ff) begin
         if (op_ff == prt_pkg::OP_LIST) begin
            // hold back one entry so the final one can carry last
            if (held_vld_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = prt_pkg::ST_ENTRY;
               rsp_addr_in   = held_addr_ff;
               rsp_port_in   = held_port_ff;
               rsp_num_in    = held_num_ff;
               rsp_last_in   = 1'b0;
            end
            held_vld_in  = 1'b1;
            held_addr_in = rd_addr_ff;
            held_port_in = rd_port_ff;
            held_num_in  = prt_pkg::NUM_W'(rd_idx_ff) + prt_pkg::NUM_W'(1);
         end else if (rd_addr_ff == addr_ff && rd_port_ff == port_ff) begin
            dup_in = 1'b1;
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = '0;
         rsp_port_in  = '0;
         rsp_num_in   = '0;
         rsp_last_in  = 1'b1;
         if (op_ff == prt_pkg::OP_LIST) begin
            if (held_vld_ff) begin
               rsp_status_in = prt_pkg::ST_ENTRY;
               rsp_addr_in   = held_addr_ff;
               rsp_port_in   = held_port_ff;
               rsp_num_in    = held_num_ff;
            end else begin
               rsp_status_in = prt_pkg::ST_EMPTY;
            end
         end else if (dup_ff) begin
            rsp_status_in = prt_pkg::ST_DUP;
         end else if (full) begin
            rsp_status_in = prt_pkg::ST_FULL;
         end else begin
            mem_we            = 1'b1;
            active_in[wr_idx] = 1'b1;
            fill_in           = fill_ff + CNT_W'(1);
            rsp_status_in     = prt_pkg::ST_OK;
            rsp_num_in        = fill_num + prt_pkg::NUM_W'(1);
         end
      end

      if (cmd.remove) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = '0;
         rsp_port_in  = '0;
         rsp_num_in   = '0;
         rsp_last_in  = 1'b1;
         if (rm_hit) begin
            active_in[rm_idx] = 1'b0;
            rsp_status_in     = prt_pkg::ST_OK;
         end else begin
            rsp_status_in = prt_pkg::ST_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         fill_ff      <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         dup_ff       <= 1'b0;
         held_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         dup_ff       <= dup_in;
         held_vld_ff  <= held_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_type;
         addr_ff   <= req_peer_addr;
         port_ff   <= req_peer_port;
         number_ff <= req_peer_number;
      end
      rd_act_ff     <= active_ff[scan_idx];
      rd_idx_ff     <= scan_idx;
      held_addr_ff  <= held_addr_in;
      held_port_ff  <= held_port_in;
      held_num_ff   <= held_num_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         addr_mem[wr_idx] <= addr_ff;
         port_mem[wr_idx] <= port_ff;
      end
      rd_addr_ff <= addr_mem[scan_idx];
      rd_port_ff <= port_mem[scan_idx];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_addr   = rsp_addr_ff;
   assign rsp_entry_port   = rsp_port_ff;
   assign rsp_entry_number = rsp_num_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> design/peer_registry_table.sv
// peer registry table: up to CAPACITY peers (address, port), numbered slot index plus one.
// request channel: start with req_type and the req_peer_* fields; a transaction is taken
// when start is high and busy is low. register (0) appends a peer unless an active entry
// has the same address and port or every slot is used; remove (1) retires an active entry
// by number; list (2) returns every active entry in slot order; code 3 is dropped.
// response channel: rsp_valid marks each result for exactly one cycle; the receiver
// cannot stall, results must be taken when shown. rsp_last marks the final result.
// sequence: register and list pass from acceptance through a load step, slot reads
// from the slot memory one per cycle, a finish step and the output register; list
// entries stream out as active slots are read, at most one per cycle. remove passes
// through a load step, a remove step and the output register. busy drops with the
// final result.
// reset empties the table at once; slot contents need no clearing.
module peer_registry_table #(
   parameter int CAPACITY = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [prt_pkg::OP_W-1:0]     req_type,
   input  logic [prt_pkg::ADDR_W-1:0]   req_peer_addr,
   input  logic [prt_pkg::PORT_W-1:0]   req_peer_port,
   input  logic [prt_pkg::NUM_W-1:0]    req_peer_number,
   output logic                         rsp_valid,
   output logic [prt_pkg::STATUS_W-1:0] rsp_status,
   output logic [prt_pkg::ADDR_W-1:0]   rsp_entry_addr,
   output logic [prt_pkg::PORT_W-1:0]   rsp_entry_port,
   output logic [prt_pkg::NUM_W-1:0]    rsp_entry_number,
   output logic                         rsp_last
);

   prt_pkg::cmd_type  cmd;
   prt_pkg::stat_type stat;

   prt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   prt_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_peer_addr    (req_peer_addr),
      .req_peer_port    (req_peer_port),
      .req_peer_number  (req_peer_number),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_entry_addr   (rsp_entry_addr),
      .rsp_entry_port   (rsp_entry_port),
      .rsp_entry_number (rsp_entry_number),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in progress");

   a_only_list_streams: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == prt_pkg::ST_ENTRY)
      else $error("non-final result that is not a list entry");

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type != prt_pkg::OP_NONE |=> busy)
      else $error("accepted transaction did not start");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after a final result");
`endif

endmodule
